/* src/rmnh_pkg.sv */
// Shared constants, operand codes and controller/datapath interface types.
package rmnh_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int T_BITS         = 31;
    localparam int FRAC_BITS      = 16;
    localparam int EPS_BITS       = 16;
    localparam logic [T_BITS-1:0] T_MAX = {T_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAR      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EPS      = 4'd7;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // First multiplier operand: a short vector.
    typedef enum logic [1:0] {
        A_DIR = 2'd0,
        A_E1  = 2'd1,
        A_E2  = 2'd2,
        A_S   = 2'd3
    } a_grp_t;

    // Second multiplier operand: a short vector or a cross product half.
    typedef enum logic [1:0] {
        B_E1 = 2'd0,
        B_E2 = 2'd1,
        B_H  = 2'd2,
        B_Q  = 2'd3
    } b_grp_t;

    // Where a finished accumulation is written.
    typedef enum logic [2:0] {
        DST_H   = 3'd0,
        DST_Q   = 3'd1,
        DST_DET = 3'd2,
        DST_U   = 3'd3,
        DST_V   = 3'd4,
        DST_T   = 3'd5
    } dst_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        a_grp_t     a_grp;
        logic [1:0] a_comp;
        b_grp_t     b_grp;
        logic [1:0] b_comp;
        logic       b_hi;
        logic       neg;
        logic       clr;
        logic       wr;
        dst_t       dst;
        logic [1:0] dst_comp;
        logic       check;
        logic       verify;
        logic       div_step;
        logic       update;
    } dp_cmd_t;

    typedef struct packed {
        logic go;
        logic last;
        logic out_free;
    } dp_sts_t;

    // Next component index in cyclic order x, y, z.
    function automatic logic [1:0] comp_next(input logic [1:0] c);
        logic [1:0] r;
        unique case (c)
            COMP_X:  r = COMP_Y;
            COMP_Y:  r = COMP_Z;
            default: r = COMP_X;
        endcase
        return r;
    endfunction

endpackage

/* src/rmnh_ctrl.sv */
// Sequencer that steps the shared multiplier, the checks and the divider.
module rmnh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rmnh_pkg::dp_sts_t sts,
    output rmnh_pkg::dp_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CROSS  = 8'b0000_0010,
        ST_DOTS   = 8'b0000_0100,
        ST_DRAIN  = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_VERIFY = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_UPDATE = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] vec_reg, vec_next;
    logic [1:0] comp_reg, comp_next;
    logic       term_reg, term_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic       seq_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign seq_end  = term_reg && (comp_reg == rmnh_pkg::COMP_Z);

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        vec_next     = vec_reg;
        comp_next    = comp_reg;
        term_next    = term_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                vec_next  = 2'd0;
                comp_next = rmnh_pkg::COMP_X;
                term_next = 1'b0;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS: begin
                cmd.mul_en   = 1'b1;
                cmd.clr      = !term_reg;
                cmd.wr       = term_reg;
                cmd.neg      = term_reg;
                cmd.dst_comp = comp_reg;
                if (!term_reg) begin
                    cmd.a_comp = rmnh_pkg::comp_next(comp_reg);
                    cmd.b_comp = rmnh_pkg::comp_next(rmnh_pkg::comp_next(comp_reg));
                end else begin
                    cmd.a_comp = rmnh_pkg::comp_next(rmnh_pkg::comp_next(comp_reg));
                    cmd.b_comp = rmnh_pkg::comp_next(comp_reg);
                end
                if (vec_reg == 2'd0) begin
                    cmd.a_grp = rmnh_pkg::A_DIR;
                    cmd.b_grp = rmnh_pkg::B_E2;
                    cmd.dst   = rmnh_pkg::DST_H;
                end else begin
                    cmd.a_grp = rmnh_pkg::A_S;
                    cmd.b_grp = rmnh_pkg::B_E1;
                    cmd.dst   = rmnh_pkg::DST_Q;
                end
                term_next = !term_reg;
                if (term_reg) comp_next = rmnh_pkg::comp_next(comp_reg);
                if (seq_end) begin
                    if (vec_reg == 2'd1) begin
                        vec_next   = 2'd0;
                        state_next = ST_DOTS;
                    end else begin
                        vec_next = vec_reg + 2'd1;
                    end
                end
            end
            ST_DOTS: begin
                cmd.mul_en = 1'b1;
                cmd.a_comp = comp_reg;
                cmd.b_comp = comp_reg;
                cmd.b_hi   = term_reg;
                cmd.clr    = !term_reg && (comp_reg == rmnh_pkg::COMP_X);
                cmd.wr     = seq_end;
                unique case (vec_reg)
                    2'd0: begin
                        cmd.a_grp = rmnh_pkg::A_E1;
                        cmd.b_grp = rmnh_pkg::B_H;
                        cmd.dst   = rmnh_pkg::DST_DET;
                    end
                    2'd1: begin
                        cmd.a_grp = rmnh_pkg::A_S;
                        cmd.b_grp = rmnh_pkg::B_H;
                        cmd.dst   = rmnh_pkg::DST_U;
                    end
                    2'd2: begin
                        cmd.a_grp = rmnh_pkg::A_DIR;
                        cmd.b_grp = rmnh_pkg::B_Q;
                        cmd.dst   = rmnh_pkg::DST_V;
                    end
                    default: begin
                        cmd.a_grp = rmnh_pkg::A_E2;
                        cmd.b_grp = rmnh_pkg::B_Q;
                        cmd.dst   = rmnh_pkg::DST_T;
                    end
                endcase
                term_next = !term_reg;
                if (term_reg) comp_next = rmnh_pkg::comp_next(comp_reg);
                if (seq_end) begin
                    vec_next = vec_reg + 2'd1;
                    if (vec_reg == 2'd3) state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_VERIFY;
            end
            ST_VERIFY: begin
                cmd.verify   = 1'b1;
                div_cnt_next = 5'd0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (!sts.go) begin
                    state_next = ST_UPDATE;
                end else begin
                    cmd.div_step = 1'b1;
                    div_cnt_next = div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'(rmnh_pkg::T_BITS - 1)) state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!sts.last || sts.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and sequence counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vec_reg     <= 2'd0;
            comp_reg    <= rmnh_pkg::COMP_X;
            term_reg    <= 1'b0;
            div_cnt_reg <= 5'd0;
        end else begin
            state_reg   <= state_next;
            vec_reg     <= vec_next;
            comp_reg    <= comp_next;
            term_reg    <= term_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // A new request is only taken with the sequencer at rest.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_CROSS)
        else $error("load did not start the cross products");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> sts.go)
        else $error("divide step on a rejected triangle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> state_reg == ST_CHECK)
        else $error("drain did not hand over to check");

endmodule

/* src/rmnh_dp.sv */
// Datapath: operand registers, shared multiplier, accumulator, checks, divider.
module rmnh_dp #(
    parameter int COORD_BITS = rmnh_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [rmnh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmnh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [287:0]                        s_tdata,
    input  logic                                s_tlast,
    input  rmnh_pkg::dp_cmd_t                   cmd,
    output rmnh_pkg::dp_sts_t                   sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,
    output logic                                m_tuser
);

    localparam int XW  = (COORD_BITS > 32) ? COORD_BITS : 32;
    localparam int D   = COORD_BITS + 1;
    localparam int PW  = 2 * D + 1;
    localparam int AW  = 3 * D + 4;
    localparam int DVW = AW + rmnh_pkg::T_BITS;
    localparam int TB  = rmnh_pkg::T_BITS;

    // Configuration registers.
    logic [31:0]                    origin_reg [3];
    logic [31:0]                    dir_reg    [3];
    logic [TB-1:0]                  far_reg;
    logic [rmnh_pkg::EPS_BITS-1:0]  eps_reg;

    // Per-triangle operands.
    logic signed [D-1:0]  dv_reg [3];
    logic signed [D-1:0]  e1_reg [3];
    logic signed [D-1:0]  e2_reg [3];
    logic signed [D-1:0]  sv_reg [3];
    logic signed [PW-1:0] h_reg  [3];
    logic signed [PW-1:0] q_reg  [3];
    logic                 last_reg;

    // Multiply and accumulate.
    logic signed [D-1:0]  a_op;
    logic signed [D:0]    b_op;
    logic signed [PW-1:0] x_sel;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_reg;
    logic                 pv_reg, pneg_reg, pclr_reg, pwr_reg, phi_reg;
    rmnh_pkg::dst_t       pdst_reg;
    logic [1:0]           pcomp_reg;
    logic signed [AW-1:0] acc_reg, acc_next, term_a, term_s;
    logic signed [AW-1:0] det_reg, un_reg, vn_reg, tn_reg;

    // Checks and divide.
    logic signed [AW-1:0] detp_reg, unp_reg, vnp_reg, tnp_reg;
    logic signed [AW-1:0] uv_sum;
    logic                 ok_reg, sat_reg, ok_c, sat_c;
    logic [DVW-1:0]       rem_reg, dvs_reg, num_w, den_w;
    logic [TB-1:0]        quo_reg;

    // Running minimum and result register.
    logic [TB-1:0] best_reg, best_next, t_val;
    logic          any_reg, any_next, take;
    logic          out_valid_reg, out_hit_reg, hit_c;
    logic [TB-1:0] out_t_reg;

    function automatic logic signed [D-1:0] to_op(input logic [31:0] v);
        logic [XW-1:0]               ext;
        logic signed [COORD_BITS-1:0] c;
        ext = XW'(v);
        c   = ext[COORD_BITS-1:0];
        return D'(c);
    endfunction

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= 32'h0001_0000;
            far_reg       <= rmnh_pkg::T_MAX;
            eps_reg       <= '0;
        end else if (cfg_valid) begin
            priority case (cfg_index)
                rmnh_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                rmnh_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                rmnh_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                rmnh_pkg::REG_DIR_X:    dir_reg[0]    <= cfg_data;
                rmnh_pkg::REG_DIR_Y:    dir_reg[1]    <= cfg_data;
                rmnh_pkg::REG_DIR_Z:    dir_reg[2]    <= cfg_data;
                rmnh_pkg::REG_FAR:      far_reg       <= cfg_data[TB-1:0];
                rmnh_pkg::REG_EPS:      eps_reg       <= cfg_data[rmnh_pkg::EPS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Edge and offset vectors are formed when the triangle is taken.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                dv_reg[i] <= to_op(dir_reg[i]);
                e1_reg[i] <= to_op(s_tdata[96+32*i +: 32]) - to_op(s_tdata[32*i +: 32]);
                e2_reg[i] <= to_op(s_tdata[192+32*i +: 32]) - to_op(s_tdata[32*i +: 32]);
                sv_reg[i] <= to_op(origin_reg[i]) - to_op(s_tdata[32*i +: 32]);
            end
            last_reg <= s_tlast;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.a_grp)
            rmnh_pkg::A_DIR: a_op = dv_reg[cmd.a_comp];
            rmnh_pkg::A_E1:  a_op = e1_reg[cmd.a_comp];
            rmnh_pkg::A_E2:  a_op = e2_reg[cmd.a_comp];
            default:         a_op = sv_reg[cmd.a_comp];
        endcase
        x_sel = (cmd.b_grp == rmnh_pkg::B_H) ? h_reg[cmd.b_comp] : q_reg[cmd.b_comp];
        unique case (cmd.b_grp)
            rmnh_pkg::B_E1: b_op = (D+1)'(e1_reg[cmd.b_comp]);
            rmnh_pkg::B_E2: b_op = (D+1)'(e2_reg[cmd.b_comp]);
            default: begin
                if (cmd.b_hi) b_op = x_sel[PW-1:D];
                else          b_op = $signed({1'b0, x_sel[D-1:0]});
            end
        endcase
    end

    assign prod = a_op * b_op;

    // Product register and delayed accumulate controls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.mul_en;
        end
        prod_reg  <= prod;
        pneg_reg  <= cmd.neg;
        pclr_reg  <= cmd.clr;
        pwr_reg   <= cmd.wr;
        phi_reg   <= cmd.b_hi;
        pdst_reg  <= cmd.dst;
        pcomp_reg <= cmd.dst_comp;
    end

    // Accumulator: the upper half of a long operand carries weight 2^D.
    always_comb begin
        term_a   = phi_reg ? (AW'(prod_reg) <<< D) : AW'(prod_reg);
        term_s   = pneg_reg ? -term_a : term_a;
        acc_next = (pclr_reg ? '0 : acc_reg) + term_s;
    end

    always_ff @(posedge aclk) begin
        if (pv_reg) begin
            acc_reg <= acc_next;
            if (pwr_reg) begin
                unique case (pdst_reg)
                    rmnh_pkg::DST_H:   h_reg[pcomp_reg] <= acc_next[PW-1:0];
                    rmnh_pkg::DST_Q:   q_reg[pcomp_reg] <= acc_next[PW-1:0];
                    rmnh_pkg::DST_DET: det_reg <= acc_next;
                    rmnh_pkg::DST_U:   un_reg  <= acc_next;
                    rmnh_pkg::DST_V:   vn_reg  <= acc_next;
                    default:           tn_reg  <= acc_next;
                endcase
            end
        end
    end

    // Sign correction, then the acceptance tests and divide setup.
    assign uv_sum = unp_reg + vnp_reg;
    assign num_w  = DVW'(tnp_reg) << rmnh_pkg::FRAC_BITS;
    assign den_w  = DVW'(detp_reg) << TB;
    assign ok_c   = (detp_reg > AW'(eps_reg)) && !unp_reg[AW-1] && (unp_reg <= detp_reg)
                    && !vnp_reg[AW-1] && (uv_sum <= detp_reg) && !tnp_reg[AW-1];
    assign sat_c  = (num_w >= den_w);

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            detp_reg <= det_reg[AW-1] ? -det_reg : det_reg;
            unp_reg  <= det_reg[AW-1] ? -un_reg  : un_reg;
            vnp_reg  <= det_reg[AW-1] ? -vn_reg  : vn_reg;
            tnp_reg  <= det_reg[AW-1] ? -tn_reg  : tn_reg;
        end
        if (cmd.verify) begin
            ok_reg  <= ok_c;
            sat_reg <= sat_c;
            rem_reg <= num_w;
            dvs_reg <= DVW'(detp_reg) << (TB - 1);
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_reg >= dvs_reg) begin
                rem_reg <= rem_reg - dvs_reg;
                quo_reg <= {quo_reg[TB-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[TB-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end

    // Running minimum and the mesh result.
    always_comb begin
        t_val     = sat_reg ? rmnh_pkg::T_MAX : quo_reg;
        take      = ok_reg && (t_val < best_reg);
        best_next = take ? t_val : best_reg;
        any_next  = any_reg || take;
        hit_c     = any_next && (best_next != '0) && (best_next < far_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= rmnh_pkg::T_MAX;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // The output register fills on a mesh result and empties when taken.
            if (cmd.update && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.update) begin
                if (last_reg) begin
                    best_reg    <= rmnh_pkg::T_MAX;
                    any_reg     <= 1'b0;
                    out_hit_reg <= hit_c;
                    out_t_reg   <= hit_c ? best_next : '0;
                end else begin
                    best_reg <= best_next;
                    any_reg  <= any_next;
                end
            end
        end
    end

    assign sts.go       = ok_reg && !sat_reg;
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tuser      = out_hit_reg;
    assign m_tdata      = {1'b0, out_t_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        !any_reg |-> best_reg == rmnh_pkg::T_MAX)
        else $error("best t moved without an accepted triangle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_hit_reg) |-> out_t_reg == '0)
        else $error("miss result carries a nonzero t");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> ok_reg && !sat_reg)
        else $error("divider ran on a rejected or saturated triangle");

endmodule

/* src/ray_mesh_nearest_hit.sv */
// Top level: nearest ray-triangle hit over a streamed mesh.
// Each triangle runs 12 multiplies for the cross products and 24 for the dot products
// through one shared multiplier, then checks and, unless it is rejected or saturated,
// a 31-step restoring divide. A new triangle is taken only while the sequencer is idle;
// a mesh result is registered at the last triangle's update and waits in an output register.
// Synchronous active-low reset restores the register defaults and clears the mesh state.
module ray_mesh_nearest_hit #(
    parameter int COORD_BITS = rmnh_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmnh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmnh_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [287:0]                     s_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
    input  logic                             s_tlast,  // last_triangle
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,  // nearest_t[30:0], zero pad
    output logic                             m_tuser   // hit
);

    rmnh_pkg::dp_cmd_t cmd;
    rmnh_pkg::dp_sts_t sts;
    logic              s_ready_c;

    assign cfg_ready = 1'b1;
    assign s_tready  = s_ready_c;

    rmnh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_ready_c),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmnh_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the nearest ray-triangle hit block.
module testbench;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] t_word;
    } mesh_hit_t;

    // Scoreboard: tracks ray registers and mesh state, queues expected mesh results.
    class hit_board;
        logic [31:0] ray_reg[8];
        logic [31:0] best_t;
        logic        any_hit;
        mesh_hit_t   expected_hits[$];
        int          errors;

        function new();
            reset_state();
            errors = 0;
        endfunction

        function void reset_state();
            foreach (ray_reg[i]) ray_reg[i] = '0;
            ray_reg[rmnh_pkg::REG_DIR_Z] = 32'd65536;
            ray_reg[rmnh_pkg::REG_FAR]   = 32'h7FFFFFFF;
            best_t  = 32'h7FFFFFFF;
            any_hit = 1'b0;
        endfunction

        function void write_reg(logic [rmnh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                rmnh_pkg::REG_ORIGIN_X, rmnh_pkg::REG_ORIGIN_Y, rmnh_pkg::REG_ORIGIN_Z,
                rmnh_pkg::REG_DIR_X, rmnh_pkg::REG_DIR_Y,
                rmnh_pkg::REG_DIR_Z: ray_reg[idx] = data;
                rmnh_pkg::REG_FAR: ray_reg[idx] = {1'b0, data[30:0]};
                rmnh_pkg::REG_EPS: ray_reg[idx] = {16'd0, data[15:0]};
                default: ;
            endcase
        endfunction

        function wide_t ext(logic [31:0] v);
            return wide_t'($signed(v));
        endfunction

        // Exact Moller-Trumbore test; returns 1 on acceptance with the Q16.16 distance.
        function bit triangle_t(logic [287:0] vtx, output logic [31:0] t_q);
            wide_t o[3], d[3], a[3], e1[3], e2[3], s[3], h[3], q[3];
            wide_t det, un, vn, tn, num;
            logic [255:0] quo;
            t_q = '0;
            for (int i = 0; i < 3; i++) begin
                o[i]  = ext(ray_reg[i]);
                d[i]  = ext(ray_reg[3 + i]);
                a[i]  = ext(vtx[32*i +: 32]);
                e1[i] = ext(vtx[32*(3 + i) +: 32]) - a[i];
                e2[i] = ext(vtx[32*(6 + i) +: 32]) - a[i];
                s[i]  = o[i] - a[i];
            end
            h[0] = d[1] * e2[2] - d[2] * e2[1];
            h[1] = d[2] * e2[0] - d[0] * e2[2];
            h[2] = d[0] * e2[1] - d[1] * e2[0];
            q[0] = s[1] * e1[2] - s[2] * e1[1];
            q[1] = s[2] * e1[0] - s[0] * e1[2];
            q[2] = s[0] * e1[1] - s[1] * e1[0];
            det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
            un  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
            vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
            tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
            if (det < 0) begin
                det = -det;
                un  = -un;
                vn  = -vn;
                tn  = -tn;
            end
            if (det <= wide_t'(ray_reg[rmnh_pkg::REG_EPS])) return 1'b0;
            if (un < 0 || un > det) return 1'b0;
            if (vn < 0 || un + vn > det) return 1'b0;
            if (tn < 0) return 1'b0;
            num = tn <<< 16;
            if (num >= (det <<< 31)) begin
                t_q = 32'h7FFFFFFF;
            end else begin
                quo = 256'(num) / 256'(det);
                t_q = quo[31:0];
            end
            return 1'b1;
        endfunction

        function void note_triangle(logic [287:0] vtx, logic last);
            logic [31:0] t_q;
            mesh_hit_t   r;
            if (triangle_t(vtx, t_q) && t_q < best_t) begin
                best_t  = t_q;
                any_hit = 1'b1;
            end
            if (last) begin
                r.hit    = any_hit && best_t > 0 && best_t < ray_reg[rmnh_pkg::REG_FAR];
                r.t_word = r.hit ? best_t : 32'd0;
                expected_hits.push_back(r);
                best_t  = 32'h7FFFFFFF;
                any_hit = 1'b0;
            end
        endfunction

        function void check_result(logic hit, logic [31:0] t_word);
            mesh_hit_t e;
            if (expected_hits.size() == 0) begin
                $error("unexpected result: hit=%0d nearest_t=%h", hit, t_word);
                errors++;
                return;
            end
            e = expected_hits.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, actual %0d", e.hit, hit);
                errors++;
            end
            if (t_word !== e.t_word) begin
                $error("nearest_t: expected %h, actual %h", e.t_word, t_word);
                errors++;
            end
        endfunction
    endclass

    localparam int Q = 65536;
    localparam int STALL_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    hit_board board = new();
    bit  calm = 1'b0;
    int  tri_count = 0;
    int  idle_cycles = 0;

    ray_mesh_nearest_hit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Observe every accepted request on all channels and keep the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                board.note_triangle(s_tdata, s_tlast);
                tri_count++;
            end
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ray_mesh_nearest_hit: mismatch");
                $finish;
            end
        end
    end

    // Result side: random stall bursts plus one long hold while triangles keep coming.
    int  stall_left = 0;
    int  hold_left = 0;
    bit  held = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!held && tri_count >= 300) begin
            held = 1'b1;
            hold_left = 3000;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Valid stays high across back-to-back writes; the caller drops it afterwards.
    task automatic write_cfg(logic [3:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] far_q, logic [31:0] eps);
        write_cfg(rmnh_pkg::REG_ORIGIN_X, ox);
        write_cfg(rmnh_pkg::REG_ORIGIN_Y, oy);
        write_cfg(rmnh_pkg::REG_ORIGIN_Z, oz);
        write_cfg(rmnh_pkg::REG_DIR_X, dx);
        write_cfg(rmnh_pkg::REG_DIR_Y, dy);
        write_cfg(rmnh_pkg::REG_DIR_Z, dz);
        write_cfg(rmnh_pkg::REG_FAR, far_q);
        write_cfg(rmnh_pkg::REG_EPS, eps);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tri(logic [287:0] vtx, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= vtx;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    function automatic logic [287:0] pack_tri(int ax, int ay, int az, int bx, int by, int bz,
                                              int cx, int cy, int cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    // Stop offering triangles, wait for every mesh result, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.expected_hits.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic int small_coord(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // A triangle near the ray, so that hits are common.
    function automatic logic [287:0] near_tri();
        logic [287:0] v;
        int z;
        z = small_coord(20 * Q);
        for (int i = 0; i < 3; i++) begin
            v[96*i +: 32]      = small_coord(3 * Q);
            v[96*i + 32 +: 32] = small_coord(3 * Q);
            v[96*i + 64 +: 32] = ($urandom_range(0, 3) == 0) ? small_coord(20 * Q)
                                                              : z + small_coord(Q);
        end
        return v;
    endfunction

    function automatic logic [287:0] wild_tri();
        logic [287:0] v;
        for (int i = 0; i < 9; i++) v[32*i +: 32] = $urandom();
        return v;
    endfunction

    task automatic random_ray();
        logic [31:0] far_q;
        int pick;
        pick = $urandom_range(0, 3);
        far_q = (pick == 0) ? 32'd1 : (pick == 1) ? 32'h7FFFFFFF
              : $urandom_range(Q, 30 * Q);
        if ($urandom_range(0, 4) == 0)
            set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        else
            set_ray(small_coord(2 * Q), small_coord(2 * Q), small_coord(2 * Q),
                    small_coord(Q / 4), small_coord(Q / 4),
                    ($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(Q / 2, 2 * Q)),
                    far_q, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : 0);
    endtask

    task automatic random_meshes(int count);
        int left;
        int n;
        left = count;
        while (left > 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                send_tri(($urandom_range(0, 5) == 0) ? wild_tri() : near_tri(), k == n - 1);
                left--;
            end
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unit ray along +z from the origin.
        set_ray(0, 0, 0, 0, 0, Q, 32'h7FFFFFFF, 0);
        write_cfg(4'd9, 32'hDEADBEEF);
        cfg_valid <= 1'b0;
        send_tri(pack_tri(-Q, -Q, 5 * Q, Q, -Q, 5 * Q, 0, Q, 5 * Q), 1'b1);
        // Hit exactly at a vertex, then along an edge.
        send_tri(pack_tri(0, 0, 3 * Q, 2 * Q, 0, 3 * Q, 0, 2 * Q, 3 * Q), 1'b1);
        send_tri(pack_tri(-Q, 0, 4 * Q, Q, 0, 4 * Q, 0, Q, 4 * Q), 1'b1);
        send_tri(pack_tri(Q, -Q, 4 * Q, -Q, Q, 4 * Q, Q, Q, 4 * Q), 1'b1);
        // Two triangles at equal distance, then a nearer one.
        send_tri(pack_tri(-Q, -Q, 2 * Q, Q, -Q, 2 * Q, 0, Q, 2 * Q), 1'b0);
        send_tri(pack_tri(-Q, -Q, 2 * Q, 0, Q, 2 * Q, Q, -Q, 2 * Q), 1'b0);
        send_tri(pack_tri(-Q, -Q, Q, Q, -Q, Q, 0, Q, Q), 1'b1);
        // Zero distance, parallel ray, behind the origin, and a triangle off to the side.
        send_tri(pack_tri(-Q, -Q, 0, Q, -Q, 0, 0, Q, 0), 1'b1);
        send_tri(pack_tri(0, 0, 0, 0, 0, Q, Q, 0, 0), 1'b1);
        send_tri(pack_tri(-Q, -Q, -3 * Q, Q, -Q, -3 * Q, 0, Q, -3 * Q), 1'b1);
        send_tri(pack_tri(5 * Q, 5 * Q, Q, 6 * Q, 5 * Q, Q, 5 * Q, 6 * Q, Q), 1'b1);
        // Coordinate extremes.
        send_tri({9{32'h80000000}}, 1'b1);
        send_tri({9{32'h7FFFFFFF}}, 1'b1);
        send_tri({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 1'b1);
        drain();

        // Tiny direction: distance saturates; smallest far limit, largest epsilon.
        set_ray(0, 0, 0, 0, 0, 1, 1, 65535);
        send_tri(pack_tri(-Q, -Q, 30000 * Q, Q, -Q, 30000 * Q, 0, Q, 30000 * Q), 1'b1);
        send_tri(pack_tri(-Q, -Q, 5 * Q, Q, -Q, 5 * Q, 0, Q, 5 * Q), 1'b1);
        drain();
        set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 0);
        send_tri(pack_tri(-Q, -Q, 5 * Q, Q, -Q, 5 * Q, 0, Q, 5 * Q), 1'b1);
        send_tri(wild_tri(), 1'b1);
        drain();

        // Random phases, each under its own ray; the last one runs without idling.
        for (int p = 0; p < 6; p++) begin
            if (p == 5) calm = 1'b1;
            random_ray();
            random_meshes(235);
        end

        if (board.errors == 0 && board.expected_hits.size() == 0) begin
            $display("ray_mesh_nearest_hit: match");
        end else begin
            $display("ray_mesh_nearest_hit: mismatch");
        end
        $finish;
    end
endmodule
